>>> rtl/gbn_pkg.sv
// shared types, constants and sequence helpers for the go-back-n link endpoint
// depends on nothing; used by gbn_ctrl, gbn_datapath and the top level
package gbn_pkg;

   // sequence space and payload sizing
   localparam int SEQ_MAX      = 7;
   localparam int SEQ_W        = 3;
   localparam int PACKET_BYTES = 5;
   localparam int DATA_W       = 8 * PACKET_BYTES;
   localparam int STORE_DEPTH  = SEQ_MAX + 1;

   localparam logic [SEQ_W-1:0] SEQ_LAST = SEQ_W'(SEQ_MAX);

   // event codes on the request channel
   localparam logic [1:0] CMD_PACKET_READY = 2'd0;
   localparam logic [1:0] CMD_FRAME_ARRIVE = 2'd1;
   localparam logic [1:0] CMD_CKSUM_ERROR  = 2'd2;
   localparam logic [1:0] CMD_TIMEOUT      = 2'd3;

   // result kinds on the response channel
   localparam logic [1:0] KIND_FRAME_SENT = 2'd0;
   localparam logic [1:0] KIND_DELIVERED  = 2'd1;
   localparam logic [1:0] KIND_REJECTED   = 2'd2;

   // commands from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic send;
      logic ack_step;
      logic deliver;
      logic rewind;
      logic resend;
   } ctrl_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic [1:0] cmd;
      logic       out_free;
      logic       ack_hit;
      logic       rx_match;
      logic       count_zero;
      logic       resend_last;
   } dp_status_type;

   // next sequence number, wrapping after the top of the space
   function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] k);
      return (k == SEQ_LAST) ? '0 : k + SEQ_W'(1);
   endfunction

   // previous sequence number, wrapping below zero
   function automatic logic [SEQ_W-1:0] seq_dec(input logic [SEQ_W-1:0] k);
      return (k == '0) ? SEQ_LAST : k - SEQ_W'(1);
   endfunction

   // a <= b < c in circular order
   function automatic logic in_window(input logic [SEQ_W-1:0] a,
                                      input logic [SEQ_W-1:0] b,
                                      input logic [SEQ_W-1:0] c);
      return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
   endfunction

endpackage

>>> rtl/gbn_ctrl.sv
// controller state machine for the go-back-n link endpoint
// depends on gbn_pkg; drives command bits into gbn_datapath
module gbn_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  gbn_pkg::dp_status_type status,
   output gbn_pkg::ctrl_cmd_type  cmd
);
   import gbn_pkg::*;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_DECODE  = 3'd1;
   localparam logic [2:0] ST_SEND    = 3'd2;
   localparam logic [2:0] ST_ACK     = 3'd3;
   localparam logic [2:0] ST_DELIVER = 3'd4;
   localparam logic [2:0] ST_RESEND  = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // one event in flight at a time
   assign req_stall = (state_ff != ST_IDLE);

   // next state and command decode
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (status.cmd)
               CMD_PACKET_READY: state_in = ST_SEND;
               CMD_FRAME_ARRIVE: state_in = ST_ACK;
               CMD_TIMEOUT: begin
                  cmd.rewind = 1'b1;
                  state_in   = status.count_zero ? ST_IDLE : ST_RESEND;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_SEND: begin
            if (status.out_free) begin
               cmd.send = 1'b1;
               state_in = ST_IDLE;
            end
         end
         // free one window slot per cycle while the ack covers it
         ST_ACK: begin
            if (status.ack_hit) begin
               cmd.ack_step = 1'b1;
            end else begin
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (!status.rx_match) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.deliver = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         // one buffered frame per transfer, oldest first
         ST_RESEND: begin
            if (status.out_free) begin
               cmd.resend = 1'b1;
               if (status.resend_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/gbn_datapath.sv
// datapath for the go-back-n link endpoint: window state, frame store and
// response register; depends on gbn_pkg and takes commands from gbn_ctrl
module gbn_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [1:0]                    req_cmd,
   input  logic [gbn_pkg::DATA_W-1:0]    req_packet_data,
   input  logic [gbn_pkg::SEQ_W-1:0]     req_rx_seq,
   input  logic [gbn_pkg::SEQ_W-1:0]     req_rx_ack,
   input  logic [gbn_pkg::DATA_W-1:0]    req_rx_data,
   input  gbn_pkg::ctrl_cmd_type         cmd,
   output gbn_pkg::dp_status_type        status,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_out_kind,
   output logic [gbn_pkg::SEQ_W-1:0]     rsp_out_seq,
   output logic [gbn_pkg::SEQ_W-1:0]     rsp_out_ack,
   output logic [gbn_pkg::DATA_W-1:0]    rsp_out_data,
   output logic                          rsp_window_open,
   output logic                          rsp_last
);
   import gbn_pkg::*;

   // captured request
   logic [1:0]        cmd_ff;
   logic [DATA_W-1:0] pdata_ff;
   logic [SEQ_W-1:0]  rseq_ff;
   logic [SEQ_W-1:0]  rack_ff;
   logic [DATA_W-1:0] rdata_ff;

   // window state
   logic [SEQ_W-1:0] next_ff, next_in;
   logic [SEQ_W-1:0] oldest_ff, oldest_in;
   logic [SEQ_W-1:0] expected_ff, expected_in;
   logic [SEQ_W-1:0] count_ff, count_in;
   logic [SEQ_W-1:0] resend_cnt_ff, resend_cnt_in;

   // frame store
   logic [DATA_W-1:0] store_mem [STORE_DEPTH];

   // response register
   logic              rsp_valid_ff;
   logic [1:0]        kind_ff, kind_in;
   logic [SEQ_W-1:0]  seq_ff, seq_in;
   logic [SEQ_W-1:0]  ack_ff, ack_in;
   logic [DATA_W-1:0] data_ff, data_in;
   logic              wopen_ff;
   logic              last_ff, last_in;

   logic out_free;
   logic room;
   logic load;
   logic store_wr;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign room     = (count_ff < SEQ_LAST);
   assign load     = cmd.send | cmd.deliver | cmd.resend;
   assign store_wr = cmd.send & room;

   // status back to the controller
   always_comb begin
      status.cmd         = cmd_ff;
      status.out_free    = out_free;
      status.ack_hit     = (count_ff != '0) && in_window(oldest_ff, rack_ff, next_ff);
      status.rx_match    = (rseq_ff == expected_ff);
      status.count_zero  = (count_ff == '0);
      status.resend_last = ((resend_cnt_ff + SEQ_W'(1)) == count_ff);
   end

   // window state updates
   always_comb begin
      next_in       = next_ff;
      oldest_in     = oldest_ff;
      expected_in   = expected_ff;
      count_in      = count_ff;
      resend_cnt_in = resend_cnt_ff;
      if (store_wr) begin
         next_in  = seq_inc(next_ff);
         count_in = count_ff + SEQ_W'(1);
      end
      if (cmd.ack_step) begin
         oldest_in = seq_inc(oldest_ff);
         count_in  = count_ff - SEQ_W'(1);
      end
      if (cmd.deliver) begin
         expected_in = seq_inc(expected_ff);
      end
      if (cmd.rewind) begin
         next_in       = oldest_ff;
         resend_cnt_in = '0;
      end
      if (cmd.resend) begin
         next_in       = seq_inc(next_ff);
         resend_cnt_in = resend_cnt_ff + SEQ_W'(1);
      end
   end

   // response field selection
   always_comb begin
      kind_in = KIND_FRAME_SENT;
      seq_in  = next_ff;
      ack_in  = seq_dec(expected_ff);
      data_in = pdata_ff;
      last_in = 1'b1;
      if (cmd.send && !room) begin
         kind_in = KIND_REJECTED;
         seq_in  = '0;
         data_in = '0;
      end
      if (cmd.deliver) begin
         kind_in = KIND_DELIVERED;
         seq_in  = rseq_ff;
         ack_in  = rseq_ff;
         data_in = rdata_ff;
      end
      if (cmd.resend) begin
         last_in = status.resend_last;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         next_ff       <= '0;
         oldest_ff     <= '0;
         expected_ff   <= '0;
         count_ff      <= '0;
         resend_cnt_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         next_ff       <= next_in;
         oldest_ff     <= oldest_in;
         expected_ff   <= expected_in;
         count_ff      <= count_in;
         resend_cnt_ff <= resend_cnt_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff   <= req_cmd;
         pdata_ff <= req_packet_data;
         rseq_ff  <= req_rx_seq;
         rack_ff  <= req_rx_ack;
         rdata_ff <= req_rx_data;
      end
   end

   // frame store write and registered read into the response payload
   always_ff @(posedge clock) begin
      if (store_wr) begin
         store_mem[next_ff] <= pdata_ff;
      end
      if (cmd.resend) begin
         data_ff <= store_mem[next_ff];
      end else if (load) begin
         data_ff <= data_in;
      end
      if (load) begin
         kind_ff  <= kind_in;
         seq_ff   <= seq_in;
         ack_ff   <= ack_in;
         wopen_ff <= (count_in < SEQ_LAST);
         last_ff  <= last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_kind    = kind_ff;
   assign rsp_out_seq     = seq_ff;
   assign rsp_out_ack     = ack_ff;
   assign rsp_out_data    = data_ff;
   assign rsp_window_open = wopen_ff;
   assign rsp_last        = last_ff;

endmodule

>>> rtl/go_back_n_link_endpoint_unit.sv
// go-back-n link endpoint, 3-bit sequence numbers, one event at a time
// order: the request is captured, then decoded; a result is registered from the send,
// deliver or resend state, and a delivery comes after the ack state frees acked slots.
// a new request is taken only once the last event is done (timeout: after each
// buffered frame is resent); response stalls hold the send, deliver and resend states
// reset: synchronous, clears window state and the response valid, store unset
module go_back_n_link_endpoint_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_cmd,
   input  logic [gbn_pkg::DATA_W-1:0]    req_packet_data,
   input  logic [gbn_pkg::SEQ_W-1:0]     req_rx_seq,
   input  logic [gbn_pkg::SEQ_W-1:0]     req_rx_ack,
   input  logic [gbn_pkg::DATA_W-1:0]    req_rx_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_out_kind,
   output logic [gbn_pkg::SEQ_W-1:0]     rsp_out_seq,
   output logic [gbn_pkg::SEQ_W-1:0]     rsp_out_ack,
   output logic [gbn_pkg::DATA_W-1:0]    rsp_out_data,
   output logic                          rsp_window_open,
   output logic                          rsp_last
);
   import gbn_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // sequencing
   gbn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // window state, frame store and response register
   gbn_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_cmd         (req_cmd),
      .req_packet_data (req_packet_data),
      .req_rx_seq      (req_rx_seq),
      .req_rx_ack      (req_rx_ack),
      .req_rx_data     (req_rx_data),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_kind    (rsp_out_kind),
      .rsp_out_seq     (rsp_out_seq),
      .rsp_out_ack     (rsp_out_ack),
      .rsp_out_data    (rsp_out_data),
      .rsp_window_open (rsp_window_open),
      .rsp_last        (rsp_last)
   );

endmodule

>>> tb/gbn_endpoint_monitor.sv
// response checker for the go-back-n link endpoint: watches both channels,
// predicts the results of each accepted event and compares them in order
// depends on gbn_pkg for widths, event codes and result kinds
`timescale 1ns / 1ps

module gbn_endpoint_monitor (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic [1:0]                 req_cmd,
   input  logic [gbn_pkg::DATA_W-1:0] req_packet_data,
   input  logic [gbn_pkg::SEQ_W-1:0]  req_rx_seq,
   input  logic [gbn_pkg::SEQ_W-1:0]  req_rx_ack,
   input  logic [gbn_pkg::DATA_W-1:0] req_rx_data,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic [1:0]                 rsp_out_kind,
   input  logic [gbn_pkg::SEQ_W-1:0]  rsp_out_seq,
   input  logic [gbn_pkg::SEQ_W-1:0]  rsp_out_ack,
   input  logic [gbn_pkg::DATA_W-1:0] rsp_out_data,
   input  logic                       rsp_window_open,
   input  logic                       rsp_last,
   output int                         error_count,
   output int                         pending_count,
   output int                         event_count,
   output int                         result_count
);
   import gbn_pkg::*;

   typedef struct packed {
      logic [1:0]        kind;
      logic [SEQ_W-1:0]  seq_no;
      logic [SEQ_W-1:0]  ack;
      logic [DATA_W-1:0] data;
      logic              window_open;
      logic              last;
   } link_out_type;

   // results still owed by the endpoint, oldest first
   link_out_type frames_due[$];

   // sender window and receiver position
   logic [SEQ_W-1:0]  tx_next;
   logic [SEQ_W-1:0]  tx_base;
   logic [SEQ_W-1:0]  tx_count;
   logic [SEQ_W-1:0]  rx_expect;
   logic [DATA_W-1:0] sent_store [STORE_DEPTH];

   // one result with the ack that holds at the moment it is made
   function automatic link_out_type make_out(input logic [1:0]        kind,
                                             input logic [SEQ_W-1:0]  seq_no,
                                             input logic [DATA_W-1:0] data);
      link_out_type r;
      r.kind        = kind;
      r.seq_no      = seq_no;
      r.ack         = rx_expect - 1'b1;
      r.data        = data;
      r.window_open = 1'b0;
      r.last        = 1'b0;
      return r;
   endfunction

   // work out the results of one event and queue them
   task automatic predict_event(input logic [1:0]        cmd,
                                input logic [DATA_W-1:0] pdata,
                                input logic [SEQ_W-1:0]  rseq,
                                input logic [SEQ_W-1:0]  rack,
                                input logic [DATA_W-1:0] rdata);
      link_out_type     batch[$];
      link_out_type     r;
      logic [SEQ_W-1:0] ack_span;
      int               k;
      batch = {};
      case (cmd)
         CMD_PACKET_READY: begin
            if (tx_count < SEQ_MAX) begin
               sent_store[tx_next] = pdata;
               tx_count = tx_count + 1'b1;
               batch.push_back(make_out(KIND_FRAME_SENT, tx_next, pdata));
               tx_next = tx_next + 1'b1;
            end else begin
               batch.push_back(make_out(KIND_REJECTED, '0, '0));
            end
         end
         CMD_FRAME_ARRIVE: begin
            if (rseq == rx_expect) begin
               rx_expect = rx_expect + 1'b1;
               batch.push_back(make_out(KIND_DELIVERED, rseq, rdata));
            end
            // cumulative ack frees everything up to and including rack
            ack_span = rack - tx_base;
            if (ack_span < tx_count) begin
               tx_base  = rack + 1'b1;
               tx_count = tx_count - ack_span - 1'b1;
            end
         end
         CMD_TIMEOUT: begin
            // go back to the oldest unacked frame and resend the lot
            tx_next = tx_base;
            for (k = 0; k < tx_count; k++) begin
               batch.push_back(make_out(KIND_FRAME_SENT, tx_next, sent_store[tx_next]));
               tx_next = tx_next + 1'b1;
            end
         end
         default: ;
      endcase
      foreach (batch[i]) begin
         r             = batch[i];
         r.window_open = (tx_count < SEQ_MAX);
         r.last        = (i == batch.size() - 1);
         frames_due.push_back(r);
      end
   endtask

   // compare one response transfer with the oldest expectation
   task automatic check_result();
      link_out_type got;
      link_out_type want;
      got.kind        = rsp_out_kind;
      got.seq_no      = rsp_out_seq;
      got.ack         = rsp_out_ack;
      got.data        = rsp_out_data;
      got.window_open = rsp_window_open;
      got.last        = rsp_last;
      result_count++;
      if (frames_due.size() == 0) begin
         error_count++;
         if (error_count <= 10)
            $display("result %0d arrived with nothing expected: kind %0d seq %0d data %h",
                     result_count, got.kind, got.seq_no, got.data);
      end else begin
         want = frames_due.pop_front();
         if (got !== want) begin
            error_count++;
            if (error_count <= 10) begin
               $display("result %0d mismatch (expected / actual):", result_count);
               $display("   kind %0d / %0d  seq %0d / %0d  ack %0d / %0d",
                        want.kind, got.kind, want.seq_no, got.seq_no, want.ack, got.ack);
               $display("   open %b / %b  last %b / %b",
                        want.window_open, got.window_open, want.last, got.last);
               $display("   data %h / %h", want.data, got.data);
            end
         end
      end
   endtask

   // handshakes are sampled on the falling edge, before the rising edge that completes them
   always @(negedge clock) begin
      if (reset) begin
         tx_next       = '0;
         tx_base       = '0;
         tx_count      = '0;
         rx_expect     = '0;
         error_count   = 0;
         event_count   = 0;
         result_count  = 0;
         frames_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall)
            check_result();
         if (req_valid && !req_stall) begin
            event_count++;
            predict_event(req_cmd, req_packet_data, req_rx_seq, req_rx_ack, req_rx_data);
         end
      end
      pending_count = frames_due.size();
   end

endmodule

>>> tb/go_back_n_link_endpoint_unit_tb.sv
// top of the go-back-n link endpoint testbench: clock, reset, event stimulus,
// response stalls and the verdict; checking is done by gbn_endpoint_monitor
// depends on gbn_pkg, gbn_endpoint_monitor and go_back_n_link_endpoint_unit
`timescale 1ns / 1ps

module go_back_n_link_endpoint_unit_tb;
   import gbn_pkg::*;

   localparam int RANDOM_EVENTS   = 430;
   localparam int CALM_TAIL       = 60;
   localparam int PRESSURE_AT     = 150;
   localparam int PRESSURE_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 32;
   localparam int CYCLE_LIMIT     = 500000;

   logic              clock           = 1'b0;
   logic              reset           = 1'b1;
   logic              req_valid       = 1'b0;
   logic              req_stall;
   logic [1:0]        req_cmd         = CMD_CKSUM_ERROR;
   logic [DATA_W-1:0] req_packet_data = '0;
   logic [SEQ_W-1:0]  req_rx_seq      = '0;
   logic [SEQ_W-1:0]  req_rx_ack      = '0;
   logic [DATA_W-1:0] req_rx_data     = '0;
   logic              rsp_valid;
   logic              rsp_stall       = 1'b0;
   logic [1:0]        rsp_out_kind;
   logic [SEQ_W-1:0]  rsp_out_seq;
   logic [SEQ_W-1:0]  rsp_out_ack;
   logic [DATA_W-1:0] rsp_out_data;
   logic              rsp_window_open;
   logic              rsp_last;

   int error_count;
   int pending_count;
   int event_count;
   int result_count;
   int cycle_count = 0;
   int directed_count = 0;

   // stimulus-side view of the window, used only to aim acks and sequence numbers
   logic [SEQ_W-1:0] sh_base   = '0;
   logic [SEQ_W-1:0] sh_count  = '0;
   logic [SEQ_W-1:0] sh_expect = '0;

   bit calm      = 1'b0;
   bit long_hold = 1'b0;

   go_back_n_link_endpoint_unit u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_packet_data (req_packet_data),
      .req_rx_seq      (req_rx_seq),
      .req_rx_ack      (req_rx_ack),
      .req_rx_data     (req_rx_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_kind    (rsp_out_kind),
      .rsp_out_seq     (rsp_out_seq),
      .rsp_out_ack     (rsp_out_ack),
      .rsp_out_data    (rsp_out_data),
      .rsp_window_open (rsp_window_open),
      .rsp_last        (rsp_last)
   );

   gbn_endpoint_monitor u_monitor (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_packet_data (req_packet_data),
      .req_rx_seq      (req_rx_seq),
      .req_rx_ack      (req_rx_ack),
      .req_rx_data     (req_rx_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_kind    (rsp_out_kind),
      .rsp_out_seq     (rsp_out_seq),
      .rsp_out_ack     (rsp_out_ack),
      .rsp_out_data    (rsp_out_data),
      .rsp_window_open (rsp_window_open),
      .rsp_last        (rsp_last),
      .error_count     (error_count),
      .pending_count   (pending_count),
      .event_count     (event_count),
      .result_count    (result_count)
   );

   // clock
   always #1 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("watchdog expired after %0d cycles, %0d results outstanding",
                  cycle_count, pending_count);
         $display("go_back_n_link_endpoint_unit_tb: errors");
         $finish;
      end
   end

   // payload with the all-zero and all-one corners mixed in
   function automatic logic [DATA_W-1:0] random_payload();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return {8'($urandom), 32'($urandom)};
      endcase
   endfunction

   // offer one event, hold it until the transfer, then track the window
   task automatic send_event(input logic [1:0]        cmd,
                             input logic [DATA_W-1:0] pdata,
                             input logic [SEQ_W-1:0]  rseq,
                             input logic [SEQ_W-1:0]  rack,
                             input logic [DATA_W-1:0] rdata);
      logic [SEQ_W-1:0] ack_span;
      if (!calm && $urandom_range(0, 99) < 15) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_packet_data <= pdata;
      req_rx_seq      <= rseq;
      req_rx_ack      <= rack;
      req_rx_data     <= rdata;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
      case (cmd)
         CMD_PACKET_READY: if (sh_count < SEQ_MAX) sh_count = sh_count + 1'b1;
         CMD_FRAME_ARRIVE: begin
            if (rseq == sh_expect) sh_expect = sh_expect + 1'b1;
            ack_span = rack - sh_base;
            if (ack_span < sh_count) begin
               sh_base  = rack + 1'b1;
               sh_count = sh_count - ack_span - 1'b1;
            end
         end
         default: ;
      endcase
   endtask

   // mostly in-order frames and in-window acks, the rest arbitrary
   task automatic random_event(input int pkt_share, output logic [1:0] cmd);
      int               roll;
      logic [SEQ_W-1:0] rseq;
      logic [SEQ_W-1:0] rack;
      roll = $urandom_range(0, 99);
      if (roll < pkt_share)
         cmd = CMD_PACKET_READY;
      else if (roll < pkt_share + (100 - pkt_share) * 6 / 10)
         cmd = CMD_FRAME_ARRIVE;
      else if (roll < pkt_share + (100 - pkt_share) * 7 / 10)
         cmd = CMD_CKSUM_ERROR;
      else
         cmd = CMD_TIMEOUT;
      rseq = ($urandom_range(0, 99) < 75) ? sh_expect : 3'($urandom);
      if (sh_count != 0 && $urandom_range(0, 99) < 70)
         rack = sh_base + 3'($urandom_range(0, sh_count - 1));
      else
         rack = 3'($urandom);
      send_event(cmd, random_payload(), rseq, rack, random_payload());
   endtask

   // response side: random stall bursts, quiet stretches and one long hold-off
   initial begin
      int hold_cycles;
      bit hold_done;
      hold_done = 1'b0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (long_hold && !hold_done) begin
            rsp_stall <= 1'b1;
            hold_cycles = 0;
            while (hold_cycles < PRESSURE_CYCLES) begin
               @(posedge clock);
               hold_cycles++;
            end
            rsp_stall <= 1'b0;
            hold_done = 1'b1;
         end else if (!calm && $urandom_range(0, 99) < 10) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(posedge clock);
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 3) == 0)
               repeat ($urandom_range(20, 60)) @(posedge clock);
         end
      end
   end

   // event stimulus and verdict
   initial begin
      int         counted;
      int         pkt_share;
      int         i;
      bit         pressure_done;
      logic [1:0] cmd_sent;
      counted       = 0;
      pkt_share     = 40;
      pressure_done = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: idle window, full window, resend, partial and stray acks
      send_event(CMD_TIMEOUT, '0, '0, '0, '0);
      send_event(CMD_CKSUM_ERROR, '1, '1, '1, '1);
      send_event(CMD_FRAME_ARRIVE, '1, 3'd5, 3'd7, '1);
      send_event(CMD_FRAME_ARRIVE, '0, sh_expect, 3'd0, '1);
      for (i = 0; i < SEQ_MAX; i++)
         send_event(CMD_PACKET_READY, (i == 0) ? '0 : (i == 1) ? '1 : random_payload(),
                    '0, '0, '0);
      send_event(CMD_PACKET_READY, random_payload(), '0, '0, '0);
      send_event(CMD_TIMEOUT, '0, '0, '0, '0);
      send_event(CMD_FRAME_ARRIVE, '0, sh_expect + 3'd3, sh_base + 3'd2, random_payload());
      send_event(CMD_FRAME_ARRIVE, '0, sh_expect, sh_base - 1'b1, random_payload());
      send_event(CMD_PACKET_READY, random_payload(), '0, '0, '0);
      send_event(CMD_FRAME_ARRIVE, '0, sh_expect + 3'd1, sh_base + sh_count - 1'b1, '1);
      send_event(CMD_TIMEOUT, '0, '0, '0, '0);
      send_event(CMD_FRAME_ARRIVE, '1, sh_expect, 3'd7, '0);
      directed_count = event_count;

      // random traffic, with the packet share changing every few dozen events
      while (counted < RANDOM_EVENTS) begin
         if (counted % 40 == 0)
            pkt_share = $urandom_range(25, 75);
         if (counted == PRESSURE_AT && !pressure_done) begin
            long_hold     = 1'b1;
            pressure_done = 1'b1;
         end
         calm = (counted >= RANDOM_EVENTS - CALM_TAIL);
         random_event(pkt_share, cmd_sent);
         if (cmd_sent != CMD_CKSUM_ERROR)
            counted++;
      end

      // drain
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d events (%0d directed) and checked %0d results in %0d cycles,",
               event_count, directed_count, result_count, cycle_count);
      $display("with stall bursts on both sides and a %0d-cycle response hold-off",
               PRESSURE_CYCLES);
      if (pending_count != 0)
         $display("%0d expected results never arrived", pending_count);
      if (error_count == 0 && pending_count == 0)
         $display("go_back_n_link_endpoint_unit_tb: clean");
      else
         $display("go_back_n_link_endpoint_unit_tb: errors");
      $finish;
   end

endmodule

>>> filelist.f
rtl/gbn_pkg.sv
rtl/gbn_ctrl.sv
rtl/gbn_datapath.sv
rtl/go_back_n_link_endpoint_unit.sv
tb/gbn_endpoint_monitor.sv
tb/go_back_n_link_endpoint_unit_tb.sv
